FILE: design/wsd_pkg.sv
// ---------------------------------------------------------------------------
// wsd_pkg: shared types and constants of the frame deframer
// Result codes, opcodes and the result record passed from the parser to the
// output stage.
// ---------------------------------------------------------------------------
package wsd_pkg;

  // result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // error codes
  localparam logic ERR_OPCODE = 1'b0;
  localparam logic ERR_LENGTH = 1'b1;

  // frame types as reported
  localparam logic [2:0] FT_CONT   = 3'd0;
  localparam logic [2:0] FT_TEXT   = 3'd1;
  localparam logic [2:0] FT_BINARY = 3'd2;
  localparam logic [2:0] FT_CLOSE  = 3'd3;
  localparam logic [2:0] FT_PING   = 3'd4;
  localparam logic [2:0] FT_PONG   = 3'd5;

  // opcodes on the wire
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // seven-bit length codes that announce an extended length
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // header byte index of the first key byte per length mode
  localparam logic [3:0] KEY_START_7  = 4'd2;
  localparam logic [3:0] KEY_START_16 = 4'd4;
  localparam logic [3:0] KEY_START_64 = 4'd10;
  localparam logic [3:0] KEY_BYTES    = 4'd4;
  // in 64-bit mode, header bytes below this index are the upper length bytes
  localparam logic [3:0] LEN64_LOW_START = 4'd6;

  typedef enum logic [1:0] {
    LM_7  = 2'd0,
    LM_16 = 2'd1,
    LM_64 = 2'd2
  } len_mode_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  frame_type;
    logic        masked;
    logic [31:0] payload_length;
    logic [7:0]  data_byte;
    logic        last;
    logic        error_code;
  } result_t;

endpackage

FILE: design/wsd_parse.sv
// ---------------------------------------------------------------------------
// wsd_parse: frame header parser and payload unmasker
// Holds the parse state and turns one received byte into at most one result
// in the same cycle.
// ---------------------------------------------------------------------------
module wsd_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,   // byte accepted this cycle
  input  logic [7:0]       in_byte,
  output logic             res_valid,
  output wsd_pkg::result_t res
);
  import wsd_pkg::*;

  typedef enum logic [4:0] {
    PH_FIRST  = 5'b00001,
    PH_SECOND = 5'b00010,
    PH_EXTLEN = 5'b00100,
    PH_KEY    = 5'b01000,
    PH_DATA   = 5'b10000
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  hdr_count, hdr_count_next;
  logic [2:0]  type_code, type_code_next;
  logic        mask_present, mask_present_next;
  len_mode_t   len_mode, len_mode_next;
  logic [31:0] length_value, length_value_next;
  logic [31:0] key_word, key_word_next;
  logic [31:0] payload_index, payload_index_next;

  logic        hdr_done;
  logic        fail;
  logic        fail_code;
  logic        data_out;
  logic [6:0]  len7;
  logic [3:0]  key_start;
  logic [3:0]  hdr_inc;
  logic [7:0]  key_byte;
  logic        data_last;
  logic        op_ok;
  logic [2:0]  op_type;

  // key start index for the current length mode
  always_comb begin
    unique case (len_mode)
      LM_16:   key_start = KEY_START_16;
      LM_64:   key_start = KEY_START_64;
      default: key_start = KEY_START_7;
    endcase
  end

  assign len7      = in_byte[6:0];
  assign hdr_inc   = hdr_count + 4'd1;
  assign key_byte  = 8'(key_word >> {~payload_index[1:0], 3'b000});
  assign data_last = (payload_index == length_value - 32'd1);

  // opcode and fin check
  always_comb begin
    op_ok   = 1'b1;
    op_type = FT_CONT;
    if (in_byte[7]) begin
      case (in_byte[3:0])
        OP_TEXT:   op_type = FT_TEXT;
        OP_BINARY: op_type = FT_BINARY;
        OP_CLOSE:  op_type = FT_CLOSE;
        OP_PING:   op_type = FT_PING;
        OP_PONG:   op_type = FT_PONG;
        default:   op_ok   = 1'b0;
      endcase
    end else begin
      op_ok = (in_byte[3:0] == OP_CONT);
    end
  end

  // next state and result
  always_comb begin
    phase_next         = phase;
    hdr_count_next     = hdr_count;
    type_code_next     = type_code;
    mask_present_next  = mask_present;
    len_mode_next      = len_mode;
    length_value_next  = length_value;
    key_word_next      = key_word;
    payload_index_next = payload_index;
    hdr_done           = 1'b0;
    fail               = 1'b0;
    fail_code          = ERR_OPCODE;
    data_out           = 1'b0;
    res                = '0;

    unique case (phase)
      PH_SECOND: begin
        mask_present_next = in_byte[7];
        key_word_next     = '0;
        hdr_count_next    = KEY_START_7;
        if (len7 == LEN_CODE_16) begin
          len_mode_next     = LM_16;
          length_value_next = '0;
          phase_next        = PH_EXTLEN;
        end else if (len7 == LEN_CODE_64) begin
          len_mode_next     = LM_64;
          length_value_next = '0;
          phase_next        = PH_EXTLEN;
        end else begin
          len_mode_next     = LM_7;
          length_value_next = 32'(len7);
          if (in_byte[7]) phase_next = PH_KEY;
          else            hdr_done   = 1'b1;
        end
      end
      PH_EXTLEN: begin
        if (len_mode == LM_64 && hdr_count < LEN64_LOW_START && in_byte != 8'd0) begin
          fail      = 1'b1;
          fail_code = ERR_LENGTH;
        end else begin
          if (!(len_mode == LM_64 && hdr_count < LEN64_LOW_START)) begin
            length_value_next = {length_value[23:0], in_byte};
          end
          hdr_count_next = hdr_inc;
          if (hdr_inc == key_start) begin
            if (mask_present) phase_next = PH_KEY;
            else              hdr_done   = 1'b1;
          end
        end
      end
      PH_KEY: begin
        key_word_next  = {key_word[23:0], in_byte};
        hdr_count_next = hdr_inc;
        if (hdr_inc == key_start + KEY_BYTES) hdr_done = 1'b1;
      end
      PH_DATA: begin
        data_out           = 1'b1;
        res.kind           = KIND_PAYLOAD;
        res.data_byte      = in_byte ^ key_byte;
        res.last           = data_last;
        payload_index_next = payload_index + 32'd1;
        if (data_last) begin
          phase_next     = PH_FIRST;
          hdr_count_next = '0;
        end
      end
      default: begin
        if (op_ok) begin
          type_code_next = op_type;
          hdr_count_next = 4'd1;
          phase_next     = PH_SECOND;
        end else begin
          fail      = 1'b1;
          fail_code = ERR_OPCODE;
        end
      end
    endcase

    // header complete
    if (hdr_done) begin
      res.kind           = KIND_HEADER;
      res.frame_type     = type_code;
      res.masked         = mask_present_next;
      res.payload_length = length_value_next;
      res.last           = (length_value_next == 32'd0);
      hdr_count_next     = '0;
      payload_index_next = '0;
      phase_next         = (length_value_next == 32'd0) ? PH_FIRST : PH_DATA;
    end

    // error: restart at the next byte
    if (fail) begin
      res.kind       = KIND_ERROR;
      res.last       = 1'b1;
      res.error_code = fail_code;
      phase_next     = PH_FIRST;
      hdr_count_next = '0;
    end

    res_valid = in_valid && (hdr_done || fail || data_out);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_FIRST;
      hdr_count     <= '0;
      type_code     <= FT_CONT;
      mask_present  <= 1'b0;
      len_mode      <= LM_7;
      length_value  <= '0;
      key_word      <= '0;
      payload_index <= '0;
    end else if (in_valid) begin
      phase         <= phase_next;
      hdr_count     <= hdr_count_next;
      type_code     <= type_code_next;
      mask_present  <= mask_present_next;
      len_mode      <= len_mode_next;
      length_value  <= length_value_next;
      key_word      <= key_word_next;
      payload_index <= payload_index_next;
    end
  end

endmodule

FILE: design/websocket_frame_deframer.sv
// ---------------------------------------------------------------------------
// websocket_frame_deframer: receive-side frame deframer
// Takes one stream byte per transaction and emits header, payload and error
// results on an output stream.
// ---------------------------------------------------------------------------
// One byte is taken per clock cycle unless the output stalls, and its result is
// registered; the header parser and unmasker finish each byte in a single pass.
// A byte is accepted whenever the output register is empty or being drained,
// so a stalled output stops input only while a result waits. Header bytes
// yield no result until the header completes (one header transaction, last
// set for a zero-length frame); each payload byte yields one unmasked
// transaction; a bad opcode/FIN pair or a 64-bit length above 32 bits yields
// an error transaction with last set, and parsing restarts at the next byte.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [2:0] frame_type, [3] masked,
                                 // [35:4] payload_length, [43:36] data_byte,
                                 // [44] error_code, [47:45] zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast
);
  import wsd_pkg::*;

  logic    in_accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign s_tready  = !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;

  // parser
  wsd_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_accept),
    .in_byte   (s_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= res_valid;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {3'b000, out_res.error_code, out_res.data_byte,
                    out_res.payload_length, out_res.masked, out_res.frame_type};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

endmodule
